### src/ktwg_pkg.sv
// Shared types, codes, constants and table builders for the keypad waveform generator.
`default_nettype none

package ktwg_pkg;

  // Default wave lengths, in phase index steps
  localparam int unsigned DEF_SINE_LEN   = 392;
  localparam int unsigned DEF_SQUARE_LEN = 194;
  localparam int unsigned DEF_TRI_LEN    = 195;

  // Field and datapath widths
  localparam int unsigned SAMPLE_W = 12;   // DAC code on the output
  localparam int unsigned CODE_W   = 9;    // every table/square code fits in 9 bits
  localparam int unsigned INDEX_W  = 9;    // shared phase index
  localparam int unsigned DUTY_W   = 8;
  localparam int unsigned STEP_W   = 3;
  localparam int unsigned KEY_W    = 4;
  localparam int unsigned HALF_D   = 256;  // entries in one half of the sine table

  // Duty threshold handling
  localparam logic [DUTY_W-1:0] DUTY_RESET = 8'd98;
  localparam logic [DUTY_W-1:0] DUTY_STEP  = 8'd19;
  localparam logic [DUTY_W-1:0] DUTY_HI    = 8'd174;
  localparam logic [DUTY_W-1:0] DUTY_LO    = 8'd22;
  localparam logic [STEP_W-1:0] STEP_RESET = 3'd1;

  // Square levels
  localparam logic [CODE_W-1:0] SQ_HIGH = 9'd308;
  localparam logic [CODE_W-1:0] SQ_LOW  = 9'd1;

  // pi in unsigned Q60, truncated
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  // Command carried in tuser
  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_KEY  = 1'b1
  } cmd_e;

  // Wave selection; code 3 is never produced and reads as square
  typedef enum logic [1:0] {
    WAVE_SQUARE = 2'd0,
    WAVE_SINE   = 2'd1,
    WAVE_TRI    = 2'd2
  } wave_e;

  // Keypad codes with a meaning of their own
  localparam logic [KEY_W-1:0] KEY_DUTY_RST = 4'd0;
  localparam logic [KEY_W-1:0] KEY_STEP_1   = 4'd1;
  localparam logic [KEY_W-1:0] KEY_STEP_2   = 4'd2;
  localparam logic [KEY_W-1:0] KEY_STEP_3   = 4'd3;
  localparam logic [KEY_W-1:0] KEY_STEP_4   = 4'd4;
  localparam logic [KEY_W-1:0] KEY_STEP_5   = 4'd5;
  localparam logic [KEY_W-1:0] KEY_SINE     = 4'd6;
  localparam logic [KEY_W-1:0] KEY_TRI      = 4'd7;
  localparam logic [KEY_W-1:0] KEY_SQUARE   = 4'd8;
  localparam logic [KEY_W-1:0] KEY_DEFAULTS = 4'd9;
  localparam logic [KEY_W-1:0] KEY_STAR     = 4'd10;
  localparam logic [KEY_W-1:0] KEY_HASH     = 4'd11;

  typedef logic [CODE_W-1:0] rom_half_t [HALF_D];

  // Elaboration-time helpers below; they only build constant tables.

  // (a * b) >> 60, kept to 64 bits
  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Restoring division, returns {quotient, remainder}
  function automatic logic [127:0] udiv64(logic [63:0] n, logic [63:0] dv);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, dv}) begin
        r    = r - {1'b0, dv};
        q[b] = 1'b1;
      end
    end
    return {q, r[63:0]};
  endfunction

  // trunc(152 * sin(12.56 * i / len) + 154) in Q60 fixed point
  function automatic logic [CODE_W-1:0] sine_entry(int unsigned i, int unsigned len);
    logic [63:0]  d;
    logic [63:0]  num;
    logic [127:0] qr;
    logic [63:0]  q;
    logic [63:0]  r;
    logic [63:0]  frac;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [63:0]  p;
    logic [63:0]  whole;
    logic [63:0]  two_pi;
    logic         neg;
    logic         fracnz;
    d      = 64'(25 * len);
    num    = 64'(314) * 64'(i);
    qr     = udiv64(num, d);
    q      = qr[127:64];
    r      = qr[63:0];
    frac   = '0;
    neg    = 1'b0;
    two_pi = PI_Q60 << 1;
    for (int k = 0; k < 60; k++) begin
      r    = r << 1;
      frac = frac << 1;
      if (r >= d) begin
        r       = r - d;
        frac[0] = 1'b1;
      end
    end
    x = (q << 60) | frac;
    for (int k = 0; k < 8; k++) begin
      if (x >= two_pi) x = x - two_pi;
    end
    if (x >= PI_Q60) begin
      x   = x - PI_Q60;
      neg = 1'b1;
    end
    if (x > (PI_Q60 >> 1)) x = PI_Q60 - x;
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    // Taylor series, twenty terms past the first
    for (int k = 1; k <= 20; k++) begin
      qr   = udiv64(mul_q60(term, x2), 64'((2 * k) * (2 * k + 1)));
      term = qr[127:64];
      if ((k % 2) == 1) sum = sum - term;
      else              sum = sum + term;
    end
    p      = (sum >> 8) * 64'd152;
    whole  = p >> 52;
    fracnz = (p[51:0] != 52'd0);
    if (!neg) return CODE_W'(64'd154 + whole);
    return CODE_W'(64'd154 - whole - {63'd0, fracnz});
  endfunction

  // Triangle: rising 3.1 per step, then falling 3.18 per step, floored at 0
  function automatic logic [CODE_W-1:0] tri_entry(int unsigned i);
    int v;
    if (i < 100) return CODE_W'((31 * i) / 10);
    v = 62000 - 318 * int'(i);
    if (v < 0) return '0;
    return CODE_W'(v / 100);
  endfunction

  // One half of the sine table, entries base .. base+255
  function automatic rom_half_t build_sine(int unsigned len, int unsigned base);
    rom_half_t t;
    for (int j = 0; j < HALF_D; j++) begin
      t[j] = ((base + j) < len) ? sine_entry(base + j, len) : '0;
    end
    return t;
  endfunction

  function automatic rom_half_t build_tri(int unsigned len);
    rom_half_t t;
    for (int j = 0; j < HALF_D; j++) begin
      t[j] = (j < len) ? tri_entry(j) : '0;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

### src/keypad_table_waveform_generator_core.sv
// Keypad-driven table waveform generator: top level with settings state and handshakes.
// A tick's sample passes through the input register and then the result register before it is valid on the master side.
// Throughput: one transaction per cycle; a held result stalls the next tick in the input stage.
// Key transactions update settings and produce no output transaction.
// Reset (rst_ni low, async): square wave, step 1, duty 98, index 0, both stages empty.
// Tables are constant logic, so no fill pass is needed after reset.
`default_nettype none

module keypad_table_waveform_generator_core
  import ktwg_pkg::*;
#(
  parameter int unsigned SINE_LEN   = DEF_SINE_LEN,
  parameter int unsigned SQUARE_LEN = DEF_SQUARE_LEN,
  parameter int unsigned TRI_LEN    = DEF_TRI_LEN
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // slave side
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [3:0] key_code, [7:4] zero
  input  wire logic [0:0] s_axis_tuser,   // [0] command
  // master side
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [15:0]     m_axis_tdata,   // [11:0] sample, [15:12] zero
  output logic [1:0]      m_axis_tuser    // [1:0] waveform
);

  localparam logic [INDEX_W-1:0] SINE_L = INDEX_W'(SINE_LEN);
  localparam logic [INDEX_W-1:0] SQ_L   = INDEX_W'(SQUARE_LEN);
  localparam logic [INDEX_W-1:0] TRI_L  = INDEX_W'(TRI_LEN);

  // Input register
  logic             in_valid_q, in_valid_d;
  cmd_e             in_cmd_q;
  logic [KEY_W-1:0] in_key_q;
  logic             s_take;
  logic             adv;
  logic             tick_adv;

  // Settings and phase
  logic [1:0]         wave_q, wave_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [DUTY_W-1:0]  duty_q, duty_d;
  logic [INDEX_W-1:0] phase_q, phase_d;

  // Result register
  logic                out_valid_q, out_valid_d;
  logic [CODE_W-1:0]   out_sample_q;
  logic [1:0]          out_wave_q;

  logic [INDEX_W-1:0] cur_len;
  logic [INDEX_W-1:0] idx;
  logic [1:0]         wf;
  logic [CODE_W-1:0]  sample;
  logic               is_square;

  // Handshake: a key always drains, a tick drains when the result slot frees
  assign s_take   = s_axis_tvalid && s_axis_tready;
  assign adv      = in_valid_q && ((in_cmd_q == CMD_KEY) || !out_valid_q || m_axis_tready);
  assign tick_adv = adv && (in_cmd_q == CMD_TICK);
  assign s_axis_tready = !in_valid_q || adv;

  always_comb begin
    if (s_take)   in_valid_d = 1'b1;
    else if (adv) in_valid_d = 1'b0;
    else          in_valid_d = in_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_cmd_q <= cmd_e'(s_axis_tuser[0]);
      in_key_q <= s_axis_tdata[KEY_W-1:0];
    end
  end

  // Wave length and reported wave code; unused mode code runs as square
  always_comb begin
    unique case (wave_q)
      WAVE_SINE: begin
        cur_len = SINE_L;
        wf      = WAVE_SINE;
      end
      WAVE_TRI: begin
        cur_len = TRI_L;
        wf      = WAVE_TRI;
      end
      default: begin
        cur_len = SQ_L;
        wf      = WAVE_SQUARE;
      end
    endcase
  end

  assign is_square = (wf == WAVE_SQUARE);
  assign idx       = (phase_q >= cur_len) ? '0 : phase_q;

  ktwg_sample_unit #(
    .SINE_LEN (SINE_LEN),
    .TRI_LEN  (TRI_LEN)
  ) u_sample (
    .wave_i   (wf),
    .index_i  (idx),
    .duty_i   (duty_q),
    .sample_o (sample)
  );

  // Settings update from keys, phase advance on ticks
  always_comb begin
    wave_d  = wave_q;
    step_d  = step_q;
    duty_d  = duty_q;
    phase_d = phase_q;
    if (tick_adv) begin
      phase_d = idx + INDEX_W'(step_q);
    end else if (adv) begin
      case (in_key_q) inside
        KEY_HASH: if (is_square && (duty_q < DUTY_HI)) duty_d = duty_q + DUTY_STEP;
        KEY_STAR: if (is_square && (duty_q > DUTY_LO)) duty_d = duty_q - DUTY_STEP;
        [KEY_STEP_1:KEY_STEP_5]:
          step_d = in_key_q[STEP_W-1:0];
        KEY_SINE:   wave_d = WAVE_SINE;
        KEY_TRI:    wave_d = WAVE_TRI;
        KEY_SQUARE: wave_d = WAVE_SQUARE;
        KEY_DEFAULTS: begin
          wave_d = WAVE_SQUARE;
          step_d = STEP_RESET;
          duty_d = DUTY_RESET;
        end
        KEY_DUTY_RST: if (is_square) duty_d = DUTY_RESET;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q  <= WAVE_SQUARE;
      step_q  <= STEP_RESET;
      duty_q  <= DUTY_RESET;
      phase_q <= '0;
    end else begin
      wave_q  <= wave_d;
      step_q  <= step_d;
      duty_q  <= duty_d;
      phase_q <= phase_d;
    end
  end

  // Result register
  always_comb begin
    if (tick_adv)           out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
    else                    out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_adv) begin
      out_sample_q <= sample;
      out_wave_q   <= wf;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, SAMPLE_W'(out_sample_q)};
  assign m_axis_tuser  = out_wave_q;

endmodule

`default_nettype wire

### src/ktwg_sample_unit.sv
// Sample lookup: sine and triangle tables and the square comparator.
`default_nettype none

module ktwg_sample_unit
  import ktwg_pkg::*;
#(
  parameter int unsigned SINE_LEN = DEF_SINE_LEN,
  parameter int unsigned TRI_LEN  = DEF_TRI_LEN
) (
  input  wire logic [1:0]         wave_i,
  input  wire logic [INDEX_W-1:0] index_i,
  input  wire logic [DUTY_W-1:0]  duty_i,
  output logic      [CODE_W-1:0]  sample_o
);

  // Constant tables, built at elaboration
  localparam rom_half_t SINE_LO = build_sine(SINE_LEN, 0);
  localparam rom_half_t SINE_HI = build_sine(SINE_LEN, HALF_D);
  localparam rom_half_t TRI_ROM = build_tri(TRI_LEN);

  logic [CODE_W-1:0] sine_code;
  logic [CODE_W-1:0] tri_code;
  logic [CODE_W-1:0] sq_code;

  // Triangle index stays below TRI_LEN, so the low byte addresses it
  assign sine_code = index_i[INDEX_W-1] ? SINE_HI[index_i[7:0]] : SINE_LO[index_i[7:0]];
  assign tri_code  = TRI_ROM[index_i[7:0]];
  assign sq_code   = (index_i < {1'b0, duty_i}) ? SQ_HIGH : SQ_LOW;

  always_comb begin
    unique case (wave_i)
      WAVE_SINE: sample_o = sine_code;
      WAVE_TRI:  sample_o = tri_code;
      default:   sample_o = sq_code;
    endcase
  end

endmodule

`default_nettype wire
